[hdl/bmct_pkg.sv]
`default_nettype none

package bmct_pkg;

    localparam int unsigned BOUND_W   = 15;
    localparam int unsigned POS_W     = 14;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BOUND_W-1:0] BOUND_MAX    = 15'd16384;
    localparam logic [BOUND_W-1:0] WIDTH_RESET  = 15'd1024;
    localparam logic [BOUND_W-1:0] HEIGHT_RESET = 15'd768;
    localparam logic [POS_W-1:0]   POS_X_RESET  = 14'd512;
    localparam logic [POS_W-1:0]   POS_Y_RESET  = 14'd384;

    // raw byte bit positions, buttons are active low
    localparam int unsigned LEFT_BIT_POS  = 7;
    localparam int unsigned RIGHT_BIT_POS = 5;

    localparam int unsigned HELD_LEFT_POS  = 0;
    localparam int unsigned HELD_RIGHT_POS = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BOUND_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_HEIGHT = 2'd1;

    localparam logic [1:0] KIND_MOVE    = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    // one classified poll, handed from front to back
    typedef struct packed {
        logic             ev_move;
        logic             ev_left;
        logic             left_press;
        logic             ev_right;
        logic             right_press;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [1:0]       held;
    } poll_rec_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       button;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [1:0]       held;
        logic             last;
    } event_t;

endpackage

`default_nettype wire

[hdl/bmct_queue.sv]
`default_nettype none

module bmct_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire bmct_pkg::poll_rec_t wr_data,
    output logic                     full,
    input  wire logic                rd_en,
    output bmct_pkg::poll_rec_t      rd_data,
    output logic                     empty
);
    import bmct_pkg::*;

    poll_rec_t            slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[hdl/bmct_front.sv]
`default_nettype none

module bmct_front
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [7:0]                       x_low_and_buttons,
    input  wire logic [7:0]                       x_high_byte,
    input  wire logic [7:0]                       y_low_byte,
    input  wire logic [7:0]                       y_high_byte,
    input  wire logic                             cfg_write,
    input  wire logic [bmct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmct_pkg::BOUND_W-1:0]     cfg_data,
    input  wire logic                             q_full,
    output logic                                  q_wr,
    output bmct_pkg::poll_rec_t                   q_data
);
    import bmct_pkg::*;

    logic [BOUND_W-1:0] width_reg, width_next;
    logic [BOUND_W-1:0] height_reg, height_next;
    logic [POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [1:0]         prev_reg, prev_next;

    logic               accept;
    logic signed [7:0]  dx, dy;
    logic [1:0]         held, rise, fall;
    logic [BOUND_W-1:0] cfg_bound;
    poll_rec_t          rec;

    function automatic logic [POS_W-1:0] clamp_axis(
        input logic [POS_W-1:0]   pos,
        input logic signed [7:0]  d,
        input logic [BOUND_W-1:0] bound
    );
        logic signed [15:0] sum;
        logic [BOUND_W-1:0] lim;
        sum = $signed({2'b00, pos}) + 16'($signed(d));
        lim = bound - 1'b1;
        if (sum[15])
        begin
            return '0;
        end
        else if (sum[BOUND_W-1:0] >= bound)
        begin
            return lim[POS_W-1:0];
        end
        else
        begin
            return sum[POS_W-1:0];
        end
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;

    assign dx = $signed({x_high_byte[3:0], x_low_and_buttons[3:0]});
    assign dy = $signed({y_high_byte[3:0], y_low_byte[3:0]});

    always_comb
    begin
        held[HELD_LEFT_POS]  = !x_low_and_buttons[LEFT_BIT_POS];
        held[HELD_RIGHT_POS] = !x_low_and_buttons[RIGHT_BIT_POS];
        rise = held & ~prev_reg;
        fall = ~held & prev_reg;

        pos_x_next = accept ? clamp_axis(pos_x_reg, dx, width_reg)  : pos_x_reg;
        pos_y_next = accept ? clamp_axis(pos_y_reg, dy, height_reg) : pos_y_reg;
        prev_next  = accept ? held : prev_reg;

        rec.ev_move     = (dx != '0) || (dy != '0);
        rec.ev_left     = rise[HELD_LEFT_POS] || fall[HELD_LEFT_POS];
        rec.left_press  = rise[HELD_LEFT_POS];
        rec.ev_right    = rise[HELD_RIGHT_POS] || fall[HELD_RIGHT_POS];
        rec.right_press = rise[HELD_RIGHT_POS];
        rec.pos_x       = clamp_axis(pos_x_reg, dx, width_reg);
        rec.pos_y       = clamp_axis(pos_y_reg, dy, height_reg);
        rec.held        = held;
    end

    // quiet polls only update state, nothing goes to the back
    assign q_wr   = accept && (rec.ev_move || rec.ev_left || rec.ev_right);
    assign q_data = rec;

    always_comb
    begin
        cfg_bound   = (cfg_data > BOUND_MAX) ? BOUND_MAX : cfg_data;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write && (cfg_data != '0))
        begin
            unique case (cfg_index)
                REG_BOUND_WIDTH:  width_next  = cfg_bound;
                REG_BOUND_HEIGHT: height_next = cfg_bound;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            pos_x_reg  <= POS_X_RESET;
            pos_y_reg  <= POS_Y_RESET;
            prev_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            prev_reg   <= prev_next;
        end
    end

endmodule

`default_nettype wire

[hdl/bmct_back.sv]
`default_nettype none

module bmct_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire bmct_pkg::poll_rec_t q_data,
    output logic                     q_rd,
    output logic                     empty,
    input  wire logic                pop,
    output bmct_pkg::event_t         ev
);
    import bmct_pkg::*;

    poll_rec_t cur_reg, cur_next;
    logic      cur_valid_reg, cur_valid_next;
    logic      out_valid_reg, out_valid_next;
    event_t    out_reg, out_next;

    logic      out_free, emit, cur_done;
    logic [2:0] pend, pend_left;
    event_t    ev_now;

    always_comb
    begin
        out_free = !out_valid_reg || pop;
        emit     = cur_valid_reg && out_free;
        pend     = {cur_reg.ev_right, cur_reg.ev_left, cur_reg.ev_move};

        // move first, then left, then right
        ev_now.pos_x = cur_reg.pos_x;
        ev_now.pos_y = cur_reg.pos_y;
        ev_now.held  = cur_reg.held;
        if (pend[0])
        begin
            ev_now.kind   = KIND_MOVE;
            ev_now.button = BTN_NONE;
            pend_left     = {pend[2:1], 1'b0};
        end
        else if (pend[1])
        begin
            ev_now.kind   = cur_reg.left_press ? KIND_PRESS : KIND_RELEASE;
            ev_now.button = BTN_LEFT;
            pend_left     = {pend[2], 2'b00};
        end
        else
        begin
            ev_now.kind   = cur_reg.right_press ? KIND_PRESS : KIND_RELEASE;
            ev_now.button = BTN_RIGHT;
            pend_left     = 3'b000;
        end
        ev_now.last = (pend_left == 3'b000);

        cur_done = emit && ev_now.last;
        q_rd     = !q_empty && (!cur_valid_reg || cur_done);

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (q_rd)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
        end
        else if (emit)
        begin
            cur_next.ev_move  = pend_left[0];
            cur_next.ev_left  = pend_left[1];
            cur_next.ev_right = pend_left[2];
            cur_valid_next    = !cur_done;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (emit)
        begin
            out_next       = ev_now;
            out_valid_next = 1'b1;
        end
    end

    assign empty = !out_valid_reg;
    assign ev    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

[hdl/bus_mouse_cursor_tracker.sv]
`default_nettype none

// bus mouse cursor tracker: each pushed item is one poll of the four raw mouse
// bytes; the front part takes one item per cycle whenever the four-entry queue
// has room, updates the clamped cursor and button state on the spot and queues
// up to three events (move, left edge, right edge, in that order); the back
// part sends one event per cycle through a single output register while that
// register is free or being popped, and the first event of an item passes through
// the queue, a current-item register and the output register before it shows
// on the result ports. a poll with no motion and no button edge yields no event.
// bound writes of zero are dropped and values above 16384 saturate.

module bus_mouse_cursor_tracker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     x_low_and_buttons,
    input  wire logic [7:0]                     x_high_byte,
    input  wire logic [7:0]                     y_low_byte,
    input  wire logic [7:0]                     y_high_byte,
    input  wire logic                           cfg_write,
    input  wire logic [bmct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bmct_pkg::BOUND_W-1:0]   cfg_data,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [1:0]                          event_kind,
    output logic [1:0]                          button_id,
    output logic [bmct_pkg::POS_W-1:0]          cursor_x,
    output logic [bmct_pkg::POS_W-1:0]          cursor_y,
    output logic [1:0]                          buttons_held,
    output logic                                last_event
);
    import bmct_pkg::*;

    logic      q_wr, q_full, q_rd, q_empty;
    poll_rec_t q_wdata, q_rdata;
    event_t    ev;

    bmct_front u_front
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .x_low_and_buttons (x_low_and_buttons),
        .x_high_byte       (x_high_byte),
        .y_low_byte        (y_low_byte),
        .y_high_byte       (y_high_byte),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .q_full            (q_full),
        .q_wr              (q_wr),
        .q_data            (q_wdata)
    );

    bmct_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    bmct_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .ev      (ev)
    );

    assign event_kind   = ev.kind;
    assign button_id    = ev.button;
    assign cursor_x     = ev.pos_x;
    assign cursor_y     = ev.pos_y;
    assign buttons_held = ev.held;
    assign last_event   = ev.last;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmct_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int SEG_POLLS     = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [BOUND_W-1:0]   data;
        logic [7:0]           b0;
        logic [7:0]           b1;
        logic [7:0]           b2;
        logic [7:0]           b3;
        bit                   typed;
        int                   typed_n;
        event_t               ev;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic [7:0]           x_low_and_buttons = 8'h00;
    logic [7:0]           x_high_byte       = 8'h00;
    logic [7:0]           y_low_byte        = 8'h00;
    logic [7:0]           y_high_byte       = 8'h00;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BOUND_W-1:0]   cfg_data  = '0;
    logic                 pop       = 1'b0;
    logic                 full;
    logic                 empty;
    logic [1:0]           event_kind;
    logic [1:0]           button_id;
    logic [POS_W-1:0]     cursor_x;
    logic [POS_W-1:0]     cursor_y;
    logic [1:0]           buttons_held;
    logic                 last_event;

    // predicted block state
    logic [BOUND_W-1:0] width_bound  = WIDTH_RESET;
    logic [BOUND_W-1:0] height_bound = HEIGHT_RESET;
    logic [POS_W-1:0]   cur_x        = POS_X_RESET;
    logic [POS_W-1:0]   cur_y        = POS_Y_RESET;
    logic [1:0]         prev_held    = 2'b00;

    event_t    pending_events[$];
    stim_row_t dir_rows[$];

    int sender_idle_pct = 26;
    int recv_idle_pct   = 83;
    int cycles          = 0;
    int mismatches      = 0;
    int polls_sent      = 0;
    int events_checked  = 0;
    int reg_writes      = 0;

    bus_mouse_cursor_tracker dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .x_low_and_buttons (x_low_and_buttons),
        .x_high_byte       (x_high_byte),
        .y_low_byte        (y_low_byte),
        .y_high_byte       (y_high_byte),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .empty             (empty),
        .pop               (pop),
        .event_kind        (event_kind),
        .button_id         (button_id),
        .cursor_x          (cursor_x),
        .cursor_y          (cursor_y),
        .buttons_held      (buttons_held),
        .last_event        (last_event)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d events outstanding", cycles,
                     pending_events.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [POS_W-1:0] clamp_axis(input logic [POS_W-1:0] pos,
                                                    input logic signed [7:0] d,
                                                    input logic [BOUND_W-1:0] bound);
        int v;
        v = int'(pos) + int'(d);
        if (v < 0)
            v = 0;
        if (v >= int'(bound))
            v = int'(bound) - 1;
        return v[POS_W-1:0];
    endfunction

    function automatic logic [BOUND_W-1:0] clip_bound(input logic [BOUND_W-1:0] value,
                                                      input logic [BOUND_W-1:0] old);
        if (value == '0)
            return old;
        if (value > BOUND_MAX)
            return BOUND_MAX;
        return value;
    endfunction

    function automatic event_t cursor_event(input logic [1:0] kind, input logic [1:0] btn,
                                            input logic [1:0] held);
        event_t e;
        e.kind   = kind;
        e.button = btn;
        e.pos_x  = cur_x;
        e.pos_y  = cur_y;
        e.held   = held;
        e.last   = 1'b0;
        return e;
    endfunction

    function automatic event_t one_event(input logic [1:0] kind, input logic [1:0] btn,
                                         input int x, input int y, input logic [1:0] held);
        event_t e;
        e.kind   = kind;
        e.button = btn;
        e.pos_x  = x[POS_W-1:0];
        e.pos_y  = y[POS_W-1:0];
        e.held   = held;
        e.last   = 1'b1;
        return e;
    endfunction

    // advance the cursor and button state for one poll, return its events in order
    task automatic track_poll(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              output int n, output event_t evs[3]);
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [1:0]        held;
        logic [1:0]        rise;
        logic [1:0]        fall;
        dx = {b1[3:0], b0[3:0]};
        dy = {b3[3:0], b2[3:0]};
        held = 2'b00;
        held[HELD_LEFT_POS]  = ~b0[LEFT_BIT_POS];
        held[HELD_RIGHT_POS] = ~b0[RIGHT_BIT_POS];
        cur_x = clamp_axis(cur_x, dx, width_bound);
        cur_y = clamp_axis(cur_y, dy, height_bound);
        rise = held & ~prev_held;
        fall = ~held & prev_held;
        n = 0;
        if (dx != 0 || dy != 0)
        begin
            evs[n] = cursor_event(KIND_MOVE, BTN_NONE, held);
            n++;
        end
        if (rise[HELD_LEFT_POS] || fall[HELD_LEFT_POS])
        begin
            evs[n] = cursor_event(rise[HELD_LEFT_POS] ? KIND_PRESS : KIND_RELEASE,
                                  BTN_LEFT, held);
            n++;
        end
        if (rise[HELD_RIGHT_POS] || fall[HELD_RIGHT_POS])
        begin
            evs[n] = cursor_event(rise[HELD_RIGHT_POS] ? KIND_PRESS : KIND_RELEASE,
                                  BTN_RIGHT, held);
            n++;
        end
        if (n > 0)
            evs[n-1].last = 1'b1;
        prev_held = held;
    endtask

    task automatic send_poll(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input bit typed, input int typed_n, input event_t typed_ev);
        int     n;
        event_t evs[3];
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push              <= 1'b1;
        x_low_and_buttons <= b0;
        x_high_byte       <= b1;
        y_low_byte        <= b2;
        y_high_byte       <= b3;
        do
            @(posedge clk);
        while (full);
        track_poll(b0, b1, b2, b3, n, evs);
        if (typed)
        begin
            if (typed_n == 1)
                pending_events.push_back(typed_ev);
        end
        else
        begin
            for (int i = 0; i < n; i++)
                pending_events.push_back(evs[i]);
        end
        polls_sent++;
    endtask

    // hold off the sender until every expected event is out, then let the block settle
    task automatic drain_events();
        push <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_BOUND_WIDTH)
            width_bound = clip_bound(value, width_bound);
        else if (idx == REG_BOUND_HEIGHT)
            height_bound = clip_bound(value, height_bound);
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic stim_row_t poll_row(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3);
        stim_row_t r;
        r = '{default: '0};
        r.b0 = b0;
        r.b1 = b1;
        r.b2 = b2;
        r.b3 = b3;
        return r;
    endfunction

    function automatic stim_row_t poll_typed(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input int n, input event_t e);
        stim_row_t r;
        r = poll_row(b0, b1, b2, b3);
        r.typed   = 1'b1;
        r.typed_n = n;
        r.ev      = e;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [BOUND_W-1:0] value);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = value;
        return r;
    endfunction

    function automatic logic [7:0] pick_delta();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 8'h00;
        if (r < 7)
        begin
            v = $urandom_range(0, 16);
            return 8'(v - 8);
        end
        if (r == 7)
            return ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
        return 8'($urandom());
    endfunction

    always @(posedge clk)
    begin : check_events
        event_t got_ev;
        event_t want_ev;
        if (rst_n && pop && !empty)
        begin
            got_ev.kind   = event_kind;
            got_ev.button = button_id;
            got_ev.pos_x  = cursor_x;
            got_ev.pos_y  = cursor_y;
            got_ev.held   = buttons_held;
            got_ev.last   = last_event;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cycle %0d: unexpected event kind=%0d btn=%0d x=%0d y=%0d",
                             cycles, got_ev.kind, got_ev.button, got_ev.pos_x, got_ev.pos_y);
            end
            else
            begin
                want_ev = pending_events.pop_front();
                events_checked++;
                if (got_ev.kind !== want_ev.kind || got_ev.button !== want_ev.button ||
                    got_ev.pos_x !== want_ev.pos_x || got_ev.pos_y !== want_ev.pos_y ||
                    got_ev.held !== want_ev.held || got_ev.last !== want_ev.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"cycle %0d: event mismatch, expected kind=%0d btn=%0d ",
                                  "x=%0d y=%0d held=%0d last=%0d, got kind=%0d btn=%0d ",
                                  "x=%0d y=%0d held=%0d last=%0d"}, cycles,
                                 want_ev.kind, want_ev.button, want_ev.pos_x, want_ev.pos_y,
                                 want_ev.held, want_ev.last, got_ev.kind, got_ev.button,
                                 got_ev.pos_x, got_ev.pos_y, got_ev.held, got_ev.last);
                end
            end
        end
    end

    initial
    begin
        stim_row_t          row;
        logic [7:0]         dx;
        logic [7:0]         dy;
        logic [7:0]         b0;
        bit                 left_dn;
        bit                 right_dn;
        logic [BOUND_W-1:0] seg_w[6];
        logic [BOUND_W-1:0] seg_h[6];

        // quiet poll after reset, then single-axis moves and the delta extremes
        dir_rows.push_back(poll_typed(8'hA0, 8'h00, 8'h00, 8'h00, 0, '0));
        dir_rows.push_back(poll_typed(8'hA1, 8'h00, 8'h00, 8'h00, 1,
                                      one_event(KIND_MOVE, BTN_NONE, 513, 384, 2'b00)));
        dir_rows.push_back(poll_typed(8'hA0, 8'h08, 8'h00, 8'h00, 1,
                                      one_event(KIND_MOVE, BTN_NONE, 385, 384, 2'b00)));
        dir_rows.push_back(poll_typed(8'hA0, 8'h00, 8'h0F, 8'h07, 1,
                                      one_event(KIND_MOVE, BTN_NONE, 385, 511, 2'b00)));
        // junk in the upper nibbles must not move the cursor
        dir_rows.push_back(poll_typed(8'hF0, 8'hF0, 8'hF0, 8'hF0, 0, '0));
        dir_rows.push_back(poll_typed(8'h20, 8'h00, 8'h00, 8'h00, 1,
                                      one_event(KIND_PRESS, BTN_LEFT, 385, 511, 2'b01)));
        dir_rows.push_back(poll_typed(8'h00, 8'h00, 8'h00, 8'h00, 1,
                                      one_event(KIND_PRESS, BTN_RIGHT, 385, 511, 2'b11)));
        // move plus both releases in one poll
        dir_rows.push_back(poll_row(8'hAF, 8'h0F, 8'h00, 8'h00));
        dir_rows.push_back(poll_row(8'hA0, 8'h08, 8'h00, 8'h00));
        dir_rows.push_back(poll_row(8'hA0, 8'h08, 8'h00, 8'h00));
        dir_rows.push_back(poll_row(8'hA0, 8'h08, 8'h00, 8'h00));
        // clamp at zero
        dir_rows.push_back(poll_typed(8'hA0, 8'h08, 8'h00, 8'h00, 1,
                                      one_event(KIND_MOVE, BTN_NONE, 0, 511, 2'b00)));
        dir_rows.push_back(cfg_row(REG_BOUND_WIDTH, 15'd4));
        dir_rows.push_back(poll_typed(8'hAF, 8'h07, 8'h00, 8'h00, 1,
                                      one_event(KIND_MOVE, BTN_NONE, 3, 511, 2'b00)));
        // zero bound is dropped, spare indexes do nothing
        dir_rows.push_back(cfg_row(REG_BOUND_HEIGHT, 15'd0));
        dir_rows.push_back(cfg_row(REG_SPARE_2, 15'd5));
        dir_rows.push_back(cfg_row(REG_SPARE_3, 15'd5));
        dir_rows.push_back(poll_row(8'hA1, 8'h00, 8'h0F, 8'h07));
        // bounds above range saturate
        dir_rows.push_back(cfg_row(REG_BOUND_WIDTH, 15'h7FFF));
        dir_rows.push_back(cfg_row(REG_BOUND_HEIGHT, 15'd16385));
        dir_rows.push_back(poll_row(8'hAF, 8'h07, 8'h00, 8'h00));
        // shrink under the cursor, a button-only poll shows the clamped position
        dir_rows.push_back(cfg_row(REG_BOUND_WIDTH, 15'd1));
        dir_rows.push_back(cfg_row(REG_BOUND_HEIGHT, 15'd1));
        dir_rows.push_back(poll_typed(8'h20, 8'h00, 8'h00, 8'h00, 1,
                                      one_event(KIND_PRESS, BTN_LEFT, 0, 0, 2'b01)));
        dir_rows.push_back(poll_row(8'hAF, 8'h07, 8'h00, 8'h08));
        dir_rows.push_back(cfg_row(REG_BOUND_WIDTH, BOUND_MAX));
        dir_rows.push_back(cfg_row(REG_BOUND_HEIGHT, BOUND_MAX));
        dir_rows.push_back(poll_typed(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1,
                                      one_event(KIND_MOVE, BTN_NONE, 0, 0, 2'b00)));
        dir_rows.push_back(poll_row(8'h00, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(poll_typed(8'h0F, 8'h07, 8'h0F, 8'h07, 1,
                                      one_event(KIND_MOVE, BTN_NONE, 127, 127, 2'b11)));
        dir_rows.push_back(poll_typed(8'h20, 8'h00, 8'h00, 8'h00, 1,
                                      one_event(KIND_RELEASE, BTN_RIGHT, 127, 127, 2'b01)));

        seg_w[0] = 15'd5;
        seg_h[0] = 15'd3;
        seg_w[1] = BOUND_MAX;
        seg_h[1] = BOUND_MAX;
        seg_w[2] = 15'd1;
        seg_h[2] = 15'd1;
        seg_w[3] = 15'($urandom_range(1, 400));
        seg_h[3] = 15'($urandom_range(1, 300));
        seg_w[4] = 15'h7FFF;
        seg_h[4] = 15'd16385;
        seg_w[5] = WIDTH_RESET;
        seg_h[5] = HEIGHT_RESET;
        left_dn  = 1'b0;
        right_dn = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                drain_events();
                write_reg(row.idx, row.data);
            end
            else
                send_poll(row.b0, row.b1, row.b2, row.b3, row.typed, row.typed_n, row.ev);
        end

        for (int seg = 0; seg < 6; seg++)
        begin
            drain_events();
            if (seg < 2)
            begin
                sender_idle_pct = 26;
                recv_idle_pct   = 83;
            end
            else if (seg < 4)
            begin
                sender_idle_pct = 83;
                recv_idle_pct   = 26;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            write_reg(REG_BOUND_WIDTH, seg_w[seg]);
            write_reg(REG_BOUND_HEIGHT, seg_h[seg]);
            for (int k = 0; k < SEG_POLLS; k++)
            begin
                dx = pick_delta();
                dy = pick_delta();
                if ($urandom_range(0, 3) == 0)
                    left_dn = ~left_dn;
                if ($urandom_range(0, 3) == 0)
                    right_dn = ~right_dn;
                b0 = 8'($urandom());
                b0[3:0] = dx[3:0];
                b0[LEFT_BIT_POS]  = ~left_dn;
                b0[RIGHT_BIT_POS] = ~right_dn;
                send_poll(b0, {4'($urandom()), dx[7:4]}, {4'($urandom()), dy[3:0]},
                          {4'($urandom()), dy[7:4]}, 1'b0, 0, '0);
            end
        end

        drain_events();
        $display("covered %0d polls (%0d from the directed table) and %0d bound writes,",
                 polls_sent, dir_rows.size(), reg_writes);
        $display("checked %0d cursor events across three idling mixes, %0d mismatches",
                 events_checked, mismatches);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
